/* sv/calendar_clock_with_resync_unit_assert.svh */
// Assertion macros for the calendar clock checker.
// Every property is sampled on the rising edge of clk and is off while in reset.
`ifndef CALENDAR_CLOCK_WITH_RESYNC_UNIT_ASSERT_SVH
`define CALENDAR_CLOCK_WITH_RESYNC_UNIT_ASSERT_SVH

// Same-cycle implication
`define CCR_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define CCR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/ccr_pkg.sv */
package ccr_pkg;

  // Field widths
  localparam int unsigned SEC_W   = 6;
  localparam int unsigned MIN_W   = 6;
  localparam int unsigned HOUR_W  = 5;
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned TPS_W   = 8;
  localparam int unsigned RSY_W   = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // Item kinds
  localparam logic KIND_TICK = 1'b0;
  localparam logic KIND_LOAD = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TPS     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RESYNC  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REFUSED = 2'd2;

  // Reset values
  localparam logic [TPS_W-1:0]  TPS_RST     = 8'd4;
  localparam logic [RSY_W-1:0]  RESYNC_RST  = 16'd3600;
  localparam logic [YEAR_W-1:0] REFUSED_RST = 14'd1970;

  // Last legal value of each fixed-limit field before it rolls over
  localparam logic [SEC_W-1:0]   SEC_LAST   = 6'd59;
  localparam logic [MIN_W-1:0]   MIN_LAST   = 6'd59;
  localparam logic [HOUR_W-1:0]  HOUR_LAST  = 5'd23;
  localparam logic [MONTH_W-1:0] MONTH_LAST = 4'd12;
  localparam logic [YEAR_W-1:0]  YEAR_LAST  = 14'd9999;

  // Month lengths
  localparam logic [DAY_W-1:0] DAYS_31 = 5'd31;
  localparam logic [DAY_W-1:0] DAYS_30 = 5'd30;
  localparam logic [DAY_W-1:0] DAYS_29 = 5'd29;
  localparam logic [DAY_W-1:0] DAYS_28 = 5'd28;

  // Multiplicative inverse of 25 modulo 2^14, and the largest image of a multiple of 25
  localparam logic [YEAR_W-1:0] INV25     = 14'd7209;
  localparam logic [YEAR_W-1:0] DIV25_MAX = 14'd655;

  typedef struct packed {
    logic               kind;
    logic [DAY_W-1:0]   load_day;
    logic [MONTH_W-1:0] load_month;
    logic [YEAR_W-1:0]  load_year;
    logic [HOUR_W-1:0]  load_hour;
    logic [MIN_W-1:0]   load_minute;
    logic [SEC_W-1:0]   load_second;
  } ccr_in_t;

  typedef struct packed {
    logic [SEC_W-1:0]   cur_second;
    logic [MIN_W-1:0]   cur_minute;
    logic [HOUR_W-1:0]  cur_hour;
    logic [DAY_W-1:0]   cur_day;
    logic [MONTH_W-1:0] cur_month;
    logic [YEAR_W-1:0]  cur_year;
    logic               second_advanced;
    logic               resync_request;
    logic               load_rejected;
    logic               running;
  } ccr_out_t;

  // Control handed to each counter cell
  typedef struct packed {
    logic load;
    logic carry_in;
  } ccr_cell_ctl_t;

  // Gregorian leap year; the divisibility by 25 uses the modular inverse
  function automatic logic is_leap(input logic [YEAR_W-1:0] y);
    logic [YEAR_W-1:0] prod;
    logic              div25;
    prod  = y * INV25;
    div25 = (prod <= DIV25_MAX);
    return (y[1:0] == 2'b00) && (!div25 || (y[3:0] == 4'b0000));
  endfunction

  function automatic logic [DAY_W-1:0] days_in_month(input logic [MONTH_W-1:0] m,
                                                     input logic [YEAR_W-1:0] y);
    logic [DAY_W-1:0] d;
    case (m)
      4'd4, 4'd6, 4'd9, 4'd11: d = DAYS_30;
      4'd2:                    d = is_leap(y) ? DAYS_29 : DAYS_28;
      default:                 d = DAYS_31;
    endcase
    return d;
  endfunction

endpackage

/* sv/calendar_clock_with_resync_unit.sv */
// Calendar clock with resync countdown. One input item is taken per cycle, back to back:
// a tick or a load is applied in the cycle of its transfer, and its result appears in the
// output register on the next cycle; a new item may enter in the same cycle as the waiting
// result is taken, so the rate is one item per clock unless the result side stalls, and a
// stalled result holds the input off until it is taken. A second that
// fires ripples its carry through a row of six counter cells (second, minute, hour, day,
// month, year) within that same cycle. The clock starts stopped and waits for a load; a
// load with the refused year is rejected and leaves the state alone. Configuration writes
// are taken every cycle and are expected only while the block is idle.
module calendar_clock_with_resync_unit
  import ccr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  ccr_in_t               in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output ccr_out_t              out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [TPS_W-1:0]  tps_r;
  logic [RSY_W-1:0]  resync_seconds_r;
  logic [YEAR_W-1:0] refused_year_r;

  logic [TPS_W-1:0]  tick_count_r, tick_count_nxt;
  logic [RSY_W-1:0]  resync_left_r, resync_left_nxt;
  logic              running_r, running_nxt;
  logic              out_valid_r, out_valid_nxt;
  ccr_out_t          out_data_r;

  logic              accept_in, is_load, rejected, load_ok;
  logic              tick_live, fire, expire, advance;
  logic [TPS_W-1:0]  tc_inc;
  logic [DAY_W-1:0]  day_limit;

  logic [SEC_W-1:0]   sec_r, sec_nxt;
  logic [MIN_W-1:0]   min_r, min_nxt;
  logic [HOUR_W-1:0]  hour_r, hour_nxt;
  logic [DAY_W-1:0]   day_r, day_nxt;
  logic [MONTH_W-1:0] month_r, month_nxt;
  logic [YEAR_W-1:0]  year_r, year_nxt;
  logic               c_sec, c_min, c_hour, c_day, c_month, c_year;

  assign in_ready  = !out_valid_r || out_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Decode the transfer
  assign accept_in = in_valid && in_ready;
  assign is_load   = (in_data.kind == KIND_LOAD);
  assign rejected  = is_load && (in_data.load_year == refused_year_r);
  assign load_ok   = accept_in && is_load && !rejected;
  assign tick_live = accept_in && !is_load && running_r;

  // Count ticks, fire a second, check the countdown
  assign tc_inc  = tick_count_r + TPS_W'(1);
  assign fire    = tick_live && (tc_inc == tps_r);
  assign expire  = fire && (resync_left_r <= RSY_W'(1));
  assign advance = fire && !expire;

  always_comb begin
    tick_count_nxt  = tick_count_r;
    resync_left_nxt = resync_left_r;
    running_nxt     = running_r;
    if (tick_live) begin
      tick_count_nxt = fire ? '0 : tc_inc;
    end
    if (load_ok) begin
      resync_left_nxt = resync_seconds_r;
      running_nxt     = 1'b1;
    end else if (expire) begin
      resync_left_nxt = '0;
      running_nxt     = 1'b0;
    end else if (advance) begin
      resync_left_nxt = resync_left_r - RSY_W'(1);
    end
  end

  // Month length from the current month and year
  assign day_limit = days_in_month(month_r, year_r);

  // Carry chain of counter cells
  ccr_cell #(.W(SEC_W), .RST_VAL('0), .WRAP_VAL('0)) u_sec (
    .clk, .rst_n, .ctl('{load: load_ok, carry_in: advance}),
    .load_val(in_data.load_second), .limit(SEC_LAST),
    .carry_out(c_sec), .value_nxt(sec_nxt), .value_r(sec_r)
  );

  ccr_cell #(.W(MIN_W), .RST_VAL('0), .WRAP_VAL('0)) u_min (
    .clk, .rst_n, .ctl('{load: load_ok, carry_in: c_sec}),
    .load_val(in_data.load_minute), .limit(MIN_LAST),
    .carry_out(c_min), .value_nxt(min_nxt), .value_r(min_r)
  );

  ccr_cell #(.W(HOUR_W), .RST_VAL('0), .WRAP_VAL('0)) u_hour (
    .clk, .rst_n, .ctl('{load: load_ok, carry_in: c_min}),
    .load_val(in_data.load_hour), .limit(HOUR_LAST),
    .carry_out(c_hour), .value_nxt(hour_nxt), .value_r(hour_r)
  );

  ccr_cell #(.W(DAY_W), .RST_VAL(DAY_W'(1)), .WRAP_VAL(DAY_W'(1))) u_day (
    .clk, .rst_n, .ctl('{load: load_ok, carry_in: c_hour}),
    .load_val(in_data.load_day), .limit(day_limit),
    .carry_out(c_day), .value_nxt(day_nxt), .value_r(day_r)
  );

  ccr_cell #(.W(MONTH_W), .RST_VAL(MONTH_W'(1)), .WRAP_VAL(MONTH_W'(1))) u_month (
    .clk, .rst_n, .ctl('{load: load_ok, carry_in: c_day}),
    .load_val(in_data.load_month), .limit(MONTH_LAST),
    .carry_out(c_month), .value_nxt(month_nxt), .value_r(month_r)
  );

  ccr_cell #(.W(YEAR_W), .RST_VAL('0), .WRAP_VAL('0)) u_year (
    .clk, .rst_n, .ctl('{load: load_ok, carry_in: c_month}),
    .load_val(in_data.load_year), .limit(YEAR_LAST),
    .carry_out(c_year), .value_nxt(year_nxt), .value_r(year_r)
  );

  // Hold the result until it is taken
  assign out_valid_nxt = accept_in ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_count_r  <= '0;
      resync_left_r <= RESYNC_RST;
      running_r     <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      tick_count_r  <= tick_count_nxt;
      resync_left_r <= resync_left_nxt;
      running_r     <= running_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // Load the output register on each input transfer
  always_ff @(posedge clk) begin
    if (accept_in) begin
      out_data_r.cur_second      <= sec_nxt;
      out_data_r.cur_minute      <= min_nxt;
      out_data_r.cur_hour        <= hour_nxt;
      out_data_r.cur_day         <= day_nxt;
      out_data_r.cur_month       <= month_nxt;
      out_data_r.cur_year        <= year_nxt;
      out_data_r.second_advanced <= advance;
      out_data_r.resync_request  <= expire;
      out_data_r.load_rejected   <= rejected;
      out_data_r.running         <= running_nxt;
    end
  end

  // Take configuration writes; an unknown index is dropped. A year carry out of the
  // last cell has nowhere to go and is dropped too.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tps_r            <= TPS_RST;
      resync_seconds_r <= RESYNC_RST;
      refused_year_r   <= REFUSED_RST;
    end else if (cfg_valid && cfg_ready && !c_year) begin
      case (cfg_index)
        CFG_TPS:     tps_r            <= cfg_data[TPS_W-1:0];
        CFG_RESYNC:  resync_seconds_r <= cfg_data[RSY_W-1:0];
        CFG_REFUSED: refused_year_r   <= cfg_data[YEAR_W-1:0];
        default: ;
      endcase
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_TPS:     tps_r            <= cfg_data[TPS_W-1:0];
        CFG_RESYNC:  resync_seconds_r <= cfg_data[RSY_W-1:0];
        CFG_REFUSED: refused_year_r   <= cfg_data[YEAR_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

/* sv/ccr_cell.sv */
module ccr_cell
  import ccr_pkg::*;
#(
  parameter int unsigned   W        = SEC_W,
  parameter logic [W-1:0]  RST_VAL  = '0,
  parameter logic [W-1:0]  WRAP_VAL = '0
) (
  input  logic          clk,
  input  logic          rst_n,
  input  ccr_cell_ctl_t ctl,
  input  logic [W-1:0]  load_val,
  input  logic [W-1:0]  limit,
  output logic          carry_out,
  output logic [W-1:0]  value_nxt,
  output logic [W-1:0]  value_r
);

  // Take a load, else step on an incoming carry; roll over at or above the limit
  always_comb begin
    carry_out = 1'b0;
    value_nxt = value_r;
    if (ctl.load) begin
      value_nxt = load_val;
    end else if (ctl.carry_in) begin
      if (value_r < limit) begin
        value_nxt = value_r + W'(1);
      end else begin
        value_nxt = WRAP_VAL;
        carry_out = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      value_r <= RST_VAL;
    end else begin
      value_r <= value_nxt;
    end
  end

endmodule

/* sv/ccr_checker.sv */
`include "calendar_clock_with_resync_unit_assert.svh"

module ccr_checker
  import ccr_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     in_ready,
  input logic     out_valid,
  input logic     out_ready,
  input ccr_out_t out_data
);

  // Hold a stalled result
  `CCR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "stalled result changed")

  // Accept input whenever the output register is free
  `CCR_ASSERT_IMPL(a_ready_free, !out_valid, in_ready, "input stalled with empty output register")

  // A resync request stops the clock
  `CCR_ASSERT_IMPL(a_req_stops, out_valid && out_data.resync_request, !out_data.running, "clock running after resync request")

  // An advanced second means the clock is still running
  `CCR_ASSERT_IMPL(a_adv_runs, out_valid && out_data.second_advanced, out_data.running, "second advanced while stopped")

  // A rejected load carries no tick flags
  `CCR_ASSERT_IMPL(a_rej_alone, out_valid && out_data.load_rejected, !out_data.second_advanced && !out_data.resync_request, "rejected load with tick flags")

endmodule

bind calendar_clock_with_resync_unit ccr_checker u_ccr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
